// ===== rtl/core/hbrd_pkg.sv =====
// Shared types and codes for the happens-before race detector.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps
package hbrd_pkg;

  localparam int unsigned NumCores = 2;

  typedef logic [31:0] clk_t;
  typedef clk_t [NumCores-1:0] vclk_t;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_SYNC   = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_OTHER3 = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SYNC_ACQ_TRY = 2'd0,
    SYNC_ACQ_OK  = 2'd1,
    SYNC_RELEASE = 2'd2,
    SYNC_NONE    = 2'd3
  } sync_op_e;

  typedef enum logic {
    CFG_SHARED_MASK  = 1'b0,
    CFG_REPORT_LIMIT = 1'b1
  } cfg_idx_e;

  // One entry of the object table: the last write to an object.
  typedef struct packed {
    logic        core;
    vclk_t       clocks;
    logic [31:0] pc;
    logic [63:0] stamp;
  } obj_entry_t;

endpackage

// ===== rtl/core/happens_before_race_detector.sv =====
// Happens-before race detector: lock and object tables in synchronous memories.
// A beat's result, if any, enters the output register when stage one fires.
// Throughput: one beat per cycle. The input stalls only while stage one holds a
// beat and the output register holds a result that the receiver is stalling.
// Reset: asynchronous, active low; clocks, valid bits and the report count
// clear at once, registers take their reset values. No clearing pass is needed.
`timescale 1ns / 1ps
module happens_before_race_detector #(
  parameter int unsigned NUM_LOCKS   = 8,
  parameter int unsigned NUM_OBJECTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Trace record channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic        core_i,
  input  logic [1:0]  sync_op_i,
  input  logic        from_runtime_i,
  input  logic [2:0]  lock_id_i,
  input  logic [3:0]  object_id_i,
  input  logic        is_write_i,
  input  logic [31:0] record_pc_i,
  input  logic [63:0] timestamp_i,
  input  logic        last_record_i,
  // Conflict result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  object_o,
  output logic        writer_core_o,
  output logic        accessor_core_o,
  output logic        accessor_wrote_o,
  output logic [31:0] writer_pc_o,
  output logic [31:0] accessor_pc_o,
  output logic [63:0] time_delta_o
);
  import hbrd_pkg::*;

  localparam int unsigned LockW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned ObjW  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

  // Configuration registers.
  logic [15:0] mask_q;
  logic [3:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= 16'd14;
      limit_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHARED_MASK:  mask_q  <= cfg_wdata_i;
        CFG_REPORT_LIMIT: limit_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Stage one holds the accepted beat while the tables are read. It moves on
  // whenever the output register is empty or is being drained.
  logic s1_valid_q;
  logic out_valid_q;
  logic adv;
  logic fire;
  logic accept;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  logic [1:0]  kind_q;
  logic        core_q;
  logic [1:0]  op_q;
  logic        rt_q;
  logic [3:0]  obj_q;
  logic        wr_q;
  logic [31:0] pc_q;
  logic [63:0] ts_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      core_q <= core_i;
      op_q   <= sync_op_i;
      rt_q   <= from_runtime_i;
      obj_q  <= object_id_i;
      wr_q   <= is_write_i;
      pc_q   <= record_pc_i;
      ts_q   <= timestamp_i;
      last_q <= last_record_i;
    end
  end

  // Table indexes, for the read at acceptance and for stage one. The fold of
  // a lock or object field onto the table depth is a small constant map.
  logic [LockW-1:0] lock_map [8];
  logic [ObjW-1:0]  obj_map  [16];
  logic [LockW-1:0] rd_lock;
  logic [ObjW-1:0]  rd_obj;
  logic [LockW-1:0] lock_q;
  logic [ObjW-1:0]  oidx_q;

  always_comb begin
    for (int unsigned i = 0; i < 8; i++) begin
      lock_map[i] = LockW'(i % NUM_LOCKS);
    end
    for (int unsigned i = 0; i < 16; i++) begin
      obj_map[i] = ObjW'(i % NUM_OBJECTS);
    end
  end

  assign rd_lock = lock_map[lock_id_i];
  assign rd_obj  = obj_map[object_id_i];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lock_q <= rd_lock;
      oidx_q <= rd_obj;
    end
  end

  // Memories. A write from stage one in the same cycle as a read of the same
  // entry is forwarded into the read data register.
  vclk_t      lock_mem [NUM_LOCKS];
  obj_entry_t obj_mem  [NUM_OBJECTS];
  vclk_t      lock_rd_q;
  obj_entry_t obj_rd_q;

  logic       lock_we;
  vclk_t      lock_wdata;
  logic       obj_we;
  obj_entry_t obj_wdata;

  always_ff @(posedge clk_i) begin
    if (lock_we) begin
      lock_mem[lock_q] <= lock_wdata;
    end
    if (accept) begin
      lock_rd_q <= (lock_we && lock_q == rd_lock) ? lock_wdata : lock_mem[rd_lock];
    end
  end

  always_ff @(posedge clk_i) begin
    if (obj_we) begin
      obj_mem[oidx_q] <= obj_wdata;
    end
    if (accept) begin
      obj_rd_q <= (obj_we && oidx_q == rd_obj) ? obj_wdata : obj_mem[rd_obj];
    end
  end

  // Valid bits in flip-flops stand for the all-zero reset of both tables, so
  // the end of a trace clears them at once.
  logic [NUM_LOCKS-1:0]   lock_vld_q;
  logic [NUM_OBJECTS-1:0] obj_vld_q;
  vclk_t                  core_clk_q [NumCores];
  logic [3:0]             reports_q;

  // Stage one: tick, lock update, conflict check and object update.
  vclk_t       own;
  vclk_t       rel;
  vclk_t       own_new;
  logic        is_sync;
  logic        is_data;
  logic        wcore;
  logic        hit;

  always_comb begin
    own = core_clk_q[core_q];
    own[core_q] = own[core_q] + 32'd1;
    rel = lock_vld_q[lock_q] ? lock_rd_q : '0;
    is_sync = (kind_e'(kind_q) == KIND_SYNC) && !rt_q;
    is_data = (kind_e'(kind_q) == KIND_DATA) && mask_q[obj_q];
    own_new = own;
    if (is_sync && sync_op_e'(op_q) == SYNC_ACQ_OK) begin
      for (int j = 0; j < NumCores; j++) begin
        if (rel[j] > own[j]) begin
          own_new[j] = rel[j];
        end
      end
    end
    lock_we    = fire && is_sync && sync_op_e'(op_q) == SYNC_RELEASE;
    lock_wdata = own;
    wcore = obj_rd_q.core;
    hit = is_data && obj_vld_q[oidx_q] && (wcore != core_q)
          && (own[wcore] < obj_rd_q.clocks[wcore]) && (reports_q < limit_q);
    obj_we           = fire && is_data && wr_q;
    obj_wdata.core   = core_q;
    obj_wdata.clocks = own;
    obj_wdata.pc     = pc_q;
    obj_wdata.stamp  = ts_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_vld_q <= '0;
      obj_vld_q  <= '0;
      reports_q  <= '0;
      for (int i = 0; i < NumCores; i++) begin
        core_clk_q[i] <= '0;
      end
    end else if (fire) begin
      if (last_q) begin
        lock_vld_q <= '0;
        obj_vld_q  <= '0;
        reports_q  <= '0;
        for (int i = 0; i < NumCores; i++) begin
          core_clk_q[i] <= '0;
        end
      end else begin
        core_clk_q[core_q] <= own_new;
        if (lock_we) begin
          lock_vld_q[lock_q] <= 1'b1;
        end
        if (obj_we) begin
          obj_vld_q[oidx_q] <= 1'b1;
        end
        if (hit) begin
          reports_q <= reports_q + 4'd1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && hit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && hit) begin
      object_o         <= obj_q;
      writer_core_o    <= wcore;
      accessor_core_o  <= core_q;
      accessor_wrote_o <= wr_q;
      writer_pc_o      <= obj_rd_q.pc;
      accessor_pc_o    <= pc_q;
      time_delta_o     <= ts_q - obj_rd_q.stamp;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/happens_before_race_detector_tb.sv =====
// Self-checking testbench for the happens-before race detector.
// Depends on hbrd_pkg and the happens_before_race_detector top level.
`timescale 1ns / 1ps
module happens_before_race_detector_tb;
  import hbrd_pkg::*;

  // One trace record, at the block's field widths.
  typedef struct packed {
    kind_e       kind;
    logic        core;
    sync_op_e    op;
    logic        rt;
    logic [2:0]  lock;
    logic [3:0]  obj;
    logic        wr;
    logic [31:0] pc;
    logic [63:0] ts;
    logic        last;
  } trace_rec_t;

  // One unordered-conflict report.
  typedef struct packed {
    logic [3:0]  obj;
    logic        wcore;
    logic        acore;
    logic        awrote;
    logic [31:0] wpc;
    logic [31:0] apc;
    logic [63:0] delta;
  } conflict_t;

  // The scoreboard holds its own copy of the detector's clocks and tables
  // and queues the conflict reports that each accepted beat should cause.
  class conflict_scoreboard;
    logic [15:0] shared_mask;
    logic [3:0]  limit;
    clk_t        cclk [2][2];
    clk_t        rel_clk [8][2];
    bit          wvalid [16];
    bit          wcore [16];
    clk_t        wclk [16][2];
    logic [31:0] wpc [16];
    logic [63:0] wtime [16];
    logic [3:0]  reports;
    conflict_t   pending [$];
    int          mismatches;
    int          checked;

    function void clear_tables();
      for (int i = 0; i < 2; i++) for (int j = 0; j < 2; j++) cclk[i][j] = '0;
      for (int k = 0; k < 8; k++) for (int j = 0; j < 2; j++) rel_clk[k][j] = '0;
      for (int o = 0; o < 16; o++) begin
        wvalid[o] = 0;
        wcore[o] = 0;
        wclk[o][0] = '0;
        wclk[o][1] = '0;
        wpc[o] = '0;
        wtime[o] = '0;
      end
      reports = '0;
    endfunction

    function new();
      shared_mask = 16'd14;
      limit = 4'd8;
      mismatches = 0;
      checked = 0;
      clear_tables();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] val);
      if (idx == CFG_SHARED_MASK) shared_mask = val;
      else limit = val[3:0];
    endfunction

    // Advance the model by one accepted beat.
    function void note_record(trace_rec_t r);
      conflict_t c;
      logic      wc;
      int        o;
      o = r.obj;
      cclk[r.core][r.core] += 1;
      if (r.kind == KIND_SYNC) begin
        if (!r.rt) begin
          if (r.op == SYNC_RELEASE) begin
            rel_clk[r.lock][0] = cclk[r.core][0];
            rel_clk[r.lock][1] = cclk[r.core][1];
          end else if (r.op == SYNC_ACQ_OK) begin
            for (int j = 0; j < 2; j++)
              if (rel_clk[r.lock][j] > cclk[r.core][j]) cclk[r.core][j] = rel_clk[r.lock][j];
          end
        end
      end else if (r.kind == KIND_DATA && shared_mask[r.obj]) begin
        if (wvalid[o] && wcore[o] != r.core) begin
          wc = wcore[o];
          if (cclk[r.core][wc] < wclk[o][wc] && reports < limit) begin
            c.obj = r.obj;
            c.wcore = wc;
            c.acore = r.core;
            c.awrote = r.wr;
            c.wpc = wpc[o];
            c.apc = r.pc;
            c.delta = r.ts - wtime[o];
            pending.push_back(c);
            reports += 1;
          end
        end
        if (r.wr) begin
          wvalid[o] = 1;
          wcore[o] = r.core;
          wpc[o] = r.pc;
          wtime[o] = r.ts;
          wclk[o][0] = cclk[r.core][0];
          wclk[o][1] = cclk[r.core][1];
        end
      end
      if (r.last) clear_tables();
    endfunction

    function void check_report(conflict_t got);
      conflict_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %h", got);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic        core_i = 0;
  logic [1:0]  sync_op_i = '0;
  logic        from_runtime_i = 0;
  logic [2:0]  lock_id_i = '0;
  logic [3:0]  object_id_i = '0;
  logic        is_write_i = 0;
  logic [31:0] record_pc_i = '0;
  logic [63:0] timestamp_i = '0;
  logic        last_record_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [3:0]  object_o;
  logic        writer_core_o, accessor_core_o, accessor_wrote_o;
  logic [31:0] writer_pc_o, accessor_pc_o;
  logic [63:0] time_delta_o;

  happens_before_race_detector dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  conflict_scoreboard sb = new();
  bit   idle_on = 1;     // random bursts of idling allowed on both sides
  bit   hold_long = 0;   // receiver holds off for a long stretch
  int   beats_sent = 0;
  int   stall_left = 0;

  // Result side: random stall bursts, plus one long hold-off on request.
  // Results are sampled at the edge, outputs being stable before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_report({object_o, writer_core_o, accessor_core_o, accessor_wrote_o,
                       writer_pc_o, accessor_pc_o, time_delta_o});
    if (hold_long) out_stall_i <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_stall_i <= 1;
    end else out_stall_i <= 0;
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  // Offer one beat, hold it until accepted, then maybe idle for a burst.
  task automatic send_record(trace_rec_t r);
    in_valid_i <= 1;
    kind_i <= r.kind;
    core_i <= r.core;
    sync_op_i <= r.op;
    from_runtime_i <= r.rt;
    lock_id_i <= r.lock;
    object_id_i <= r.obj;
    is_write_i <= r.wr;
    record_pc_i <= r.pc;
    timestamp_i <= r.ts;
    last_record_i <= r.last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_record(r);
    beats_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Stop offering beats, wait until every expected report has come, then
  // let the pipeline drain.
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic trace_rec_t rand_record();
    trace_rec_t r;
    r = trace_rec_t'($bits(trace_rec_t)'({$urandom, $urandom, $urandom, $urandom}));
    r.last = ($urandom_range(0, 49) == 0);
    return r;
  endfunction

  // Mostly well-formed traffic: a few objects and locks, two cores racing
  // on writes and reads, with release and acquire pairs that sometimes order
  // the accesses. The rest is random noise.
  function automatic trace_rec_t shaped_record();
    trace_rec_t r;
    r = rand_record();
    case ($urandom_range(0, 9))
      0, 1: begin
        r.kind = KIND_SYNC;
        r.rt = ($urandom_range(0, 5) == 0);
        r.op = ($urandom_range(0, 1)) ? SYNC_RELEASE : SYNC_ACQ_OK;
        r.lock = 3'($urandom_range(0, 2));
      end
      2, 3, 4, 5, 6, 7, 8: begin
        r.kind = KIND_DATA;
        r.obj = 4'($urandom_range(0, 4));
        r.wr = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    r.ts = {32'h0, $urandom} + (($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_0000_0000 : 64'd0);
    return r;
  endfunction

  function automatic trace_rec_t mk(kind_e k, logic c, sync_op_e op, logic rt,
                                    logic [2:0] lk, logic [3:0] ob, logic wr,
                                    logic [31:0] pc, logic [63:0] ts, logic last);
    trace_rec_t r;
    r = '{k, c, op, rt, lk, ob, wr, pc, ts, last};
    return r;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: a write by core 0 races with core 1, then a release and
    // acquire orders a later access; runtime sync, acquire try, the spare
    // kind and the spare op change only the tick; an unshared object and a
    // same-core write are not checked; the last record clears the tables.
    write_reg(CFG_SHARED_MASK, 16'hFFFF);
    write_reg(CFG_REPORT_LIMIT, 16'd15);
    send_record(mk(KIND_DATA, 0, SYNC_ACQ_TRY, 0, 0, 4'd1, 1, 32'hFFFF_FFFF, 64'd0, 0));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd1, 0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd1, 1, 32'h1234, 64'd5, 0));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd1, 1, 32'h1238, 64'd6, 0));
    send_record(mk(KIND_SYNC, 1, SYNC_RELEASE, 0, 3'd7, 0, 0, 32'h40, 64'd7, 0));
    send_record(mk(KIND_SYNC, 0, SYNC_ACQ_TRY, 0, 3'd7, 0, 0, 32'h44, 64'd8, 0));
    send_record(mk(KIND_SYNC, 0, SYNC_ACQ_OK, 1, 3'd7, 0, 0, 32'h44, 64'd8, 0));
    send_record(mk(KIND_SYNC, 0, SYNC_NONE, 0, 3'd7, 0, 0, 32'h44, 64'd8, 0));
    send_record(mk(KIND_OTHER3, 0, SYNC_NONE, 1, 3'd7, 4'hF, 1, 32'h48, 64'd9, 0));
    send_record(mk(KIND_SYNC, 0, SYNC_ACQ_OK, 0, 3'd7, 0, 0, 32'h4C, 64'd10, 0));
    send_record(mk(KIND_DATA, 0, SYNC_ACQ_TRY, 0, 0, 4'd1, 1, 32'h50, 64'd11, 0));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd15, 1, 32'h60, 64'd12, 0));
    send_record(mk(KIND_DATA, 0, SYNC_ACQ_TRY, 0, 0, 4'd15, 0, 32'h64, 64'd13, 1));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd15, 1, 32'h68, 64'd14, 0));
    send_record(mk(KIND_OTHER, 0, SYNC_ACQ_TRY, 0, 0, 0, 0, 32'h6C, 64'd15, 0));
    drain();
    write_reg(CFG_SHARED_MASK, 16'h0000);
    send_record(mk(KIND_DATA, 0, SYNC_ACQ_TRY, 0, 0, 4'd15, 0, 32'h70, 64'd16, 0));
    send_record(mk(KIND_DATA, 1, SYNC_ACQ_TRY, 0, 0, 4'd0, 1, 32'h74, 64'd17, 1));
    drain();

    // Random phases across several register settings, limit zero included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SHARED_MASK, 16'hFFFF); write_reg(CFG_REPORT_LIMIT, 16'd15); end
        1: begin write_reg(CFG_SHARED_MASK, 16'd14); write_reg(CFG_REPORT_LIMIT, 16'd0); end
        2: begin write_reg(CFG_SHARED_MASK, 16'h001F); write_reg(CFG_REPORT_LIMIT, 16'd2); end
        3: begin
          write_reg(CFG_SHARED_MASK, 16'($urandom));
          write_reg(CFG_REPORT_LIMIT, 16'($urandom_range(0, 15)));
        end
        default: begin
          write_reg(CFG_SHARED_MASK, 16'hFFFF);
          write_reg(CFG_REPORT_LIMIT, 16'd15);
        end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off while the sender keeps offering beats.
        hold_long = 1;
        fork
          begin repeat (300) @(posedge clk_i); hold_long = 0; end
        join_none
      end
      if (ph == 5) idle_on = 0;
      for (int n = 0; n < 105; n++)
        send_record(($urandom_range(0, 9) == 0) ? rand_record() : shaped_record());
      drain();
    end

    $display("Sent %0d trace beats over six register settings; %0d conflict reports checked.",
             beats_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== happens_before_race_detector.f =====
rtl/core/hbrd_pkg.sv
rtl/core/happens_before_race_detector.sv
tb/happens_before_race_detector_tb.sv
